### src/hla_pkg.sv
// ----------------------------------------------------------------------------
// hla_pkg
// Shared constants, trig tables and controller/datapath interface types for
// the Hough line accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package hla_pkg;

    localparam int IMG_MAX_DIM = 512;
    localparam int THETA_BINS  = 180;
    localparam int RHO_BINS    = 724;
    localparam int MAX_PEAKS   = 64;
    localparam int WIN_RAD     = 4;
    localparam int VOTE_MAX    = 1023;

    localparam int STORE_DEPTH = THETA_BINS * RHO_BINS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int THETA_W     = 8;
    localparam int RHO_W       = 10;
    localparam int VOTE_W      = 10;
    localparam int DIM_W       = 10;
    localparam int CNT_W       = 7;
    localparam int WIN_ROW_OFS = WIN_RAD * RHO_BINS;

    localparam logic [1:0] REQ_VOTE  = 2'd0;
    localparam logic [1:0] REQ_SCAN  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] CFG_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [30:0] SQRT2_Q30   = 31'd1518500250;

    typedef logic signed [31:0] trig_tab_t [THETA_BINS];

    typedef struct packed {
        logic clr_step;
        logic load_item;
        logic vote_step;
        logic scan_init;
        logic clr_cnt;
        logic cell_chk;
        logic win_rd;
        logic win_adv;
        logic cell_adv;
        logic peak;
        logic fin;
    } hla_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic theta_last;
        logic pipe_busy;
        logic cand;
        logic win_hit;
        logic win_last;
        logic cell_last;
        logic peak_stall;
        logic out_free;
    } hla_stat_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_W'(IMG_MAX_DIM)) begin
            r = DIM_W'(IMG_MAX_DIM);
        end else begin
            r = d;
        end
        return r;
    endfunction

    function automatic logic [63:0] q30_sq_mul(input logic [63:0] term,
                                               input logic [63:0] a);
        logic [63:0] p;
        p = (term * a) >> 30;
        p = (p * a) >> 30;
        return p;
    endfunction

    function automatic logic signed [63:0] sine_fq(input logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] term;
        logic signed [63:0] sum;
        a = (a_in > HALF_PI_Q30) ? HALF_PI_Q30 : a_in;
        term = a;
        sum = signed'(a);
        term = q30_sq_mul(term, a) / 64'd6;   sum = sum - signed'(term);
        term = q30_sq_mul(term, a) / 64'd20;  sum = sum + signed'(term);
        term = q30_sq_mul(term, a) / 64'd42;  sum = sum - signed'(term);
        term = q30_sq_mul(term, a) / 64'd72;  sum = sum + signed'(term);
        term = q30_sq_mul(term, a) / 64'd110; sum = sum - signed'(term);
        term = q30_sq_mul(term, a) / 64'd156; sum = sum + signed'(term);
        term = q30_sq_mul(term, a) / 64'd210; sum = sum - signed'(term);
        term = q30_sq_mul(term, a) / 64'd272; sum = sum + signed'(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > signed'(Q30_ONE)) begin
            sum = signed'(Q30_ONE);
        end
        return sum;
    endfunction

    function automatic logic [63:0] theta_angle(input int t);
        logic [63:0] tt;
        tt = 64'(t);
        return (tt * PI_Q30 + 64'(THETA_BINS / 2)) / 64'(THETA_BINS);
    endfunction

    function automatic trig_tab_t build_sin();
        trig_tab_t tab;
        logic [63:0] a;
        for (int t = 0; t < THETA_BINS; t++) begin
            a = theta_angle(t);
            tab[t] = 32'(sine_fq((a > HALF_PI_Q30) ? (PI_Q30 - a) : a));
        end
        return tab;
    endfunction

    function automatic trig_tab_t build_cos();
        trig_tab_t tab;
        logic [63:0] a;
        for (int t = 0; t < THETA_BINS; t++) begin
            a = theta_angle(t);
            if (a <= HALF_PI_Q30) begin
                tab[t] = 32'(sine_fq(HALF_PI_Q30 - a));
            end else begin
                tab[t] = 32'(-sine_fq(a - HALF_PI_Q30));
            end
        end
        return tab;
    endfunction

    localparam trig_tab_t SIN_TAB = build_sin();
    localparam trig_tab_t COS_TAB = build_cos();

endpackage

`default_nettype wire

### src/hla_ctrl.sv
// ----------------------------------------------------------------------------
// hla_ctrl
// Sequencer for clear passes, vote sweeps and the peak scan.
// ----------------------------------------------------------------------------
`default_nettype none

module hla_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [1:0]        req_type,
    input  wire hla_pkg::hla_stat_t stat,
    output hla_pkg::hla_cmd_t      cmd
);
    import hla_pkg::*;

    localparam logic [3:0] ST_CLR    = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_VOTE   = 4'd2;
    localparam logic [3:0] ST_VDRAIN = 4'd3;
    localparam logic [3:0] ST_CRD    = 4'd4;
    localparam logic [3:0] ST_CCHK   = 4'd5;
    localparam logic [3:0] ST_WRD    = 4'd6;
    localparam logic [3:0] ST_WCHK   = 4'd7;
    localparam logic [3:0] ST_PEAK   = 4'd8;
    localparam logic [3:0] ST_NEXT   = 4'd9;
    localparam logic [3:0] ST_FIN    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.load_item = accept;
        cmd.scan_init = accept && (req_type == REQ_SCAN);
        cmd.clr_cnt   = accept && (req_type == REQ_CLEAR);
        unique case (state_reg)
            ST_CLR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (req_type)
                        REQ_VOTE:  state_next = ST_VOTE;
                        REQ_SCAN:  state_next = ST_CRD;
                        REQ_CLEAR: state_next = ST_CLR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_VOTE: begin
                cmd.vote_step = 1'b1;
                if (stat.theta_last) state_next = ST_VDRAIN;
            end
            ST_VDRAIN: begin
                if (!stat.pipe_busy) state_next = ST_IDLE;
            end
            ST_CRD: begin
                state_next = ST_CCHK;
            end
            ST_CCHK: begin
                cmd.cell_chk = 1'b1;
                state_next = stat.cand ? ST_WRD : ST_NEXT;
            end
            ST_WRD: begin
                cmd.win_rd = 1'b1;
                state_next = ST_WCHK;
            end
            ST_WCHK: begin
                if (stat.win_hit) begin
                    state_next = ST_NEXT;
                end else if (stat.win_last) begin
                    state_next = ST_PEAK;
                end else begin
                    cmd.win_adv = 1'b1;
                    state_next = ST_WRD;
                end
            end
            ST_PEAK: begin
                cmd.peak = 1'b1;
                if (!stat.peak_stall) state_next = ST_NEXT;
            end
            ST_NEXT: begin
                if (stat.cell_last) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.cell_adv = 1'b1;
                    state_next = ST_CRD;
                end
            end
            ST_FIN: begin
                cmd.fin = 1'b1;
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !stat.pipe_busy)
        else $error("item accepted while vote pipeline busy");
    a_fin_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && stat.out_free) |=> s_tready)
        else $error("scan did not return to idle");
    a_vote_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VOTE && stat.theta_last) |=> !cmd.vote_step)
        else $error("vote sweep overran");
`endif

endmodule

`default_nettype wire

### src/hla_datapath.sv
// ----------------------------------------------------------------------------
// hla_datapath
// Vote store, config registers, vote pipeline, scan walkers and result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module hla_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [9:0]         cfg_data,
    input  wire logic [23:0]        s_tdata,
    input  wire hla_pkg::hla_cmd_t  cmd,
    output hla_pkg::hla_stat_t      stat,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [31:0]             m_tdata,
    output logic [1:0]              m_tuser,
    output logic                    m_tlast
);
    import hla_pkg::*;

    // config
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [VOTE_W-1:0] thr_reg;
    logic [DIM_W-1:0]  wc, hc, m_dim;
    logic [40:0]       diag_reg;
    logic [40:0]       nr_sum;
    logic [RHO_W-1:0]  nr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(IMG_MAX_DIM);
            height_reg <= DIM_W'(IMG_MAX_DIM);
            thr_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WIDTH:     width_reg  <= cfg_data;
                CFG_HEIGHT:    height_reg <= cfg_data;
                CFG_THRESHOLD: thr_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign wc     = clamp_dim(width_reg);
    assign hc     = clamp_dim(height_reg);
    assign m_dim  = (wc > hc) ? wc : hc;
    assign nr_sum = diag_reg + 41'(1 << 29);

    always_ff @(posedge aclk) begin
        diag_reg <= 41'(m_dim) * 41'(SQRT2_Q30);
        if (nr_sum[40:30] > 11'(RHO_BINS)) begin
            nr_reg <= RHO_W'(RHO_BINS);
        end else begin
            nr_reg <= nr_sum[39:30];
        end
    end

    // memory
    logic [VOTE_W-1:0] mem [STORE_DEPTH];
    logic [VOTE_W-1:0] rd_reg;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [VOTE_W-1:0] wdata;
    logic              we;

    // clear walker
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= stat.clr_last ? '0 : clr_addr_reg + 1'b1;
        end
    end

    // vote pipeline
    logic signed [10:0] x2_reg, y2_reg;
    logic [THETA_W-1:0] vt_reg;
    logic [ADDR_W-1:0]  vbase_reg, base_a_reg, addr_b_reg, addr_c_reg;
    logic signed [42:0] pa_reg, pb_reg;
    logic               va_reg, vb_reg, vc_reg;
    logic signed [43:0] r2;
    logic [12:0]        bin_raw;
    logic [RHO_W-1:0]   bin;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            x2_reg <= $signed({1'b0, s_tdata[8:0], 1'b0}) - $signed({1'b0, wc});
            y2_reg <= $signed({1'b0, s_tdata[17:9], 1'b0}) - $signed({1'b0, hc});
        end
    end

    assign r2      = {pa_reg[42], pa_reg} + {pb_reg[42], pb_reg} + {3'b000, diag_reg};
    assign bin_raw = r2[43:31];

    always_comb begin
        if (r2[43]) begin
            bin = '0;
        end else if (bin_raw >= {3'b000, nr_reg}) begin
            bin = nr_reg - 1'b1;
        end else begin
            bin = bin_raw[RHO_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            vc_reg    <= 1'b0;
            vt_reg    <= '0;
            vbase_reg <= '0;
        end else begin
            va_reg <= cmd.vote_step;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            if (cmd.vote_step) begin
                if (stat.theta_last) begin
                    vt_reg    <= '0;
                    vbase_reg <= '0;
                end else begin
                    vt_reg    <= vt_reg + 1'b1;
                    vbase_reg <= vbase_reg + ADDR_W'(RHO_BINS);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        pa_reg     <= x2_reg * COS_TAB[vt_reg];
        pb_reg     <= y2_reg * SIN_TAB[vt_reg];
        base_a_reg <= vbase_reg;
        addr_b_reg <= base_a_reg + ADDR_W'(bin);
        addr_c_reg <= addr_b_reg;
    end

    // scan walkers
    logic [THETA_W-1:0] st_reg, wa_reg, t1_reg;
    logic [RHO_W-1:0]   sr_reg, wb_reg, r0_reg, r1_reg, r0_n;
    logic [ADDR_W-1:0]  sbase_reg, wbase_reg;
    logic [VOTE_W-1:0]  v_reg;
    logic [8:0]         t_hi;
    logic [10:0]        r_hi;

    assign t_hi = 9'(st_reg) + 9'(WIN_RAD);
    assign r_hi = 11'(sr_reg) + 11'(WIN_RAD);
    assign r0_n = (sr_reg >= RHO_W'(WIN_RAD)) ? sr_reg - RHO_W'(WIN_RAD) : '0;

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            st_reg    <= '0;
            sr_reg    <= '0;
            sbase_reg <= '0;
        end else if (cmd.cell_adv) begin
            if (sr_reg == nr_reg - 1'b1) begin
                sr_reg    <= '0;
                st_reg    <= st_reg + 1'b1;
                sbase_reg <= sbase_reg + ADDR_W'(RHO_BINS);
            end else begin
                sr_reg <= sr_reg + 1'b1;
            end
        end
        if (cmd.cell_chk) begin
            v_reg  <= rd_reg;
            wb_reg <= r0_n;
            r0_reg <= r0_n;
            if (st_reg >= THETA_W'(WIN_RAD)) begin
                wa_reg    <= st_reg - THETA_W'(WIN_RAD);
                wbase_reg <= sbase_reg - ADDR_W'(WIN_ROW_OFS);
            end else begin
                wa_reg    <= '0;
                wbase_reg <= '0;
            end
            t1_reg <= (t_hi < 9'(THETA_BINS)) ? t_hi[THETA_W-1:0] : THETA_W'(THETA_BINS - 1);
            r1_reg <= (r_hi < 11'(nr_reg)) ? r_hi[RHO_W-1:0] : nr_reg - 1'b1;
        end else if (cmd.win_adv) begin
            if (wb_reg == r1_reg) begin
                wb_reg    <= r0_reg;
                wa_reg    <= wa_reg + 1'b1;
                wbase_reg <= wbase_reg + ADDR_W'(RHO_BINS);
            end else begin
                wb_reg <= wb_reg + 1'b1;
            end
        end
    end

    // memory ports
    always_comb begin
        if (vb_reg) begin
            raddr = addr_b_reg;
        end else if (cmd.win_rd) begin
            raddr = wbase_reg + ADDR_W'(wb_reg);
        end else begin
            raddr = sbase_reg + ADDR_W'(sr_reg);
        end
        we    = cmd.clr_step || vc_reg;
        waddr = cmd.clr_step ? clr_addr_reg : addr_c_reg;
        if (cmd.clr_step) begin
            wdata = '0;
        end else if (rd_reg == VOTE_W'(VOTE_MAX)) begin
            wdata = rd_reg;
        end else begin
            wdata = rd_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    // peak collection and result register
    logic [CNT_W-1:0]   cnt_reg;
    logic               over_reg, pend_valid_reg;
    logic [THETA_W-1:0] pend_t_reg;
    logic [RHO_W-1:0]   pend_r_reg;
    logic [VOTE_W-1:0]  pend_v_reg;
    logic               m_valid_reg, lv_reg, ovf_reg, last_reg;
    logic [THETA_W-1:0] th_reg;
    logic [RHO_W-1:0]   rho_reg;
    logic [VOTE_W-1:0]  votes_reg;
    logic               out_free, take_peak, emit_mid, emit_fin;

    assign out_free  = !m_valid_reg || m_tready;
    assign take_peak = cmd.peak && !stat.peak_stall && (cnt_reg < CNT_W'(MAX_PEAKS));
    assign emit_mid  = take_peak && pend_valid_reg;
    assign emit_fin  = cmd.fin && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            over_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.scan_init) begin
                cnt_reg        <= '0;
                over_reg       <= 1'b0;
                pend_valid_reg <= 1'b0;
            end else if (cmd.clr_cnt) begin
                cnt_reg <= '0;
            end else if (take_peak) begin
                cnt_reg        <= cnt_reg + 1'b1;
                pend_valid_reg <= 1'b1;
            end else if (cmd.peak && !stat.peak_stall) begin
                over_reg <= 1'b1;
            end else if (emit_fin) begin
                pend_valid_reg <= 1'b0;
            end
            if (emit_mid || emit_fin) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_peak) begin
            pend_t_reg <= st_reg;
            pend_r_reg <= sr_reg;
            pend_v_reg <= v_reg;
        end
        if (emit_mid) begin
            lv_reg    <= 1'b1;
            th_reg    <= pend_t_reg;
            rho_reg   <= pend_r_reg;
            votes_reg <= pend_v_reg;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end else if (emit_fin) begin
            lv_reg    <= pend_valid_reg;
            th_reg    <= pend_valid_reg ? pend_t_reg : '0;
            rho_reg   <= pend_valid_reg ? pend_r_reg : '0;
            votes_reg <= pend_valid_reg ? pend_v_reg : '0;
            ovf_reg   <= pend_valid_reg && over_reg;
            last_reg  <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, votes_reg, rho_reg, th_reg};
    assign m_tuser  = {ovf_reg, lv_reg};
    assign m_tlast  = last_reg;

    // status
    always_comb begin
        stat.clr_last   = (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1));
        stat.theta_last = (vt_reg == THETA_W'(THETA_BINS - 1));
        stat.pipe_busy  = va_reg || vb_reg || vc_reg;
        stat.cand       = (rd_reg > thr_reg);
        stat.win_hit    = !((wa_reg == st_reg) && (wb_reg == sr_reg)) && (rd_reg >= v_reg);
        stat.win_last   = (wa_reg == t1_reg) && (wb_reg == r1_reg);
        stat.cell_last  = (st_reg == THETA_W'(THETA_BINS - 1)) && (sr_reg == nr_reg - 1'b1);
        stat.peak_stall = (cnt_reg < CNT_W'(MAX_PEAKS)) && pend_valid_reg && !out_free;
        stat.out_free   = out_free;
    end

`ifndef SYNTHESIS
    a_vote_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        vc_reg |-> (addr_c_reg < ADDR_W'(STORE_DEPTH)))
        else $error("vote address beyond store");
    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_PEAKS))
        else $error("peak count beyond cap");
    a_pend_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (cnt_reg != '0))
        else $error("pending peak without count");
    a_wport: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_step |-> !vc_reg)
        else $error("clear and vote write collide");
`endif

endmodule

`default_nettype wire

### src/hough_line_accumulator_core.sv
// ----------------------------------------------------------------------------
// hough_line_accumulator_core
// Hough line vote accumulator with peak scan.
// ----------------------------------------------------------------------------
// Input stream: s_tuser = request (vote, scan, clear), s_tdata = pixel x, y.
// Config channel writes image width, height and vote threshold; always ready.
// After reset the 130320-entry vote store is cleared, one entry per cycle,
// so s_tready stays low until every entry is zero. A clear request does the same.
// A vote sweeps 180 angle bins through a read-modify-write pipeline on the
// store's read and write ports: the item is accepted, the bins are swept,
// and the pipeline drains before the next item is taken.
// A scan visits every (theta, rho) cell in the rho range for the image size;
// each cell is read and checked, cells above threshold then read their window
// (up to 81 reads), and a cell with no larger or equal neighbour is a peak.
// Results leave on m_* with m_tlast on the final word of a scan; a scan
// without peaks sends one word with line_valid 0. If m_tready stays low the
// scan holds until the result register frees; one item is in work at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module hough_line_accumulator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // pixel_x[8:0], pixel_y[17:9]
    input  wire logic [1:0]  s_tuser,  // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // theta_index[7:0], rho_index[17:8], peak_votes[27:18]
    output logic [1:0]       m_tuser,  // line_valid[0], overflow[1]
    output logic             m_tlast
);
    import hla_pkg::*;

    hla_cmd_t  cmd;
    hla_stat_t stat;

    assign cfg_ready = 1'b1;

    hla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    hla_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
